// ----- rtl/bpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

   // defaults for the top-level parameters
   localparam int MAX_PATTERN_DEFAULT = 6;
   localparam int COUNT_WIDTH_DEFAULT = 24;

   // largest window the design is meant to be built with
   localparam int MAX_PATTERN_LIMIT = 16;
   localparam int BATCH_COUNT_WIDTH = $clog2(MAX_PATTERN_LIMIT + 1);

   // register geometry
   localparam int REG_BYTES       = 6;
   localparam int REG_WIDTH       = 8 * REG_BYTES;
   localparam int LENGTH_WIDTH    = 3;
   localparam int TOTAL_WIDTH     = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [REG_WIDTH-1:0]    PATTERN_RESET = 48'h2380_039B_431A;
   localparam logic [REG_WIDTH-1:0]    REPLACE_RESET = 48'h2380_039B_439A;
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET  = 3'd6;

   // depth of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN = 2'd0,
      CSR_REPLACE = 2'd1,
      CSR_LENGTH  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0]             data_out;
      logic                   last_out;
      logic [TOTAL_WIDTH-1:0] match_total;
   } rsp_type;

   // control part of one queued batch of output bytes
   typedef struct packed {
      logic [BATCH_COUNT_WIDTH-1:0] count;
      logic                         last;
      logic [TOTAL_WIDTH-1:0]       total;
   } batch_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/bpp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpp_front import bpp_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [REG_WIDTH-1:0]         csr_wdata,
   input  wire logic                         req_valid,
   input  wire req_type                      req_payload,
   output logic                              req_stall,
   output logic                              push_valid,
   output logic [MAX_PATTERN*8-1:0]          push_bytes,
   output batch_ctl_type                     push_ctl,
   input  wire logic                         queue_full
);

   localparam int LW = $clog2(MAX_PATTERN + 1);

   logic [REG_WIDTH-1:0]    pattern_ff, pattern_in;
   logic [REG_WIDTH-1:0]    replace_ff, replace_in;
   logic [LENGTH_WIDTH-1:0] length_ff, length_in;

   logic [7:0]             win_ff [MAX_PATTERN];
   logic [7:0]             win_in [MAX_PATTERN];
   logic [LW-1:0]          fill_ff, fill_in;
   logic [LW-1:0]          prot_ff, prot_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [31:0]            len_wide;
   logic [LW-1:0]          eff_len;
   logic [LW-1:0]          fill_plus;
   logic [LW-1:0]          base;
   logic [LW-1:0]          emit_count;
   logic                   can_compare;
   logic                   hit;
   logic                   accept;
   logic [7:0]             ins [MAX_PATTERN];
   logic [7:0]             patched [MAX_PATTERN];
   logic [7:0]             remain [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] in_range;
   logic [MAX_PATTERN-1:0] byte_eq;
   logic [COUNT_WIDTH-1:0] count_next;
   logic [31:0]            total_wide;

   // byte pos of a register, first byte on top; beyond the sixth reads zero
   function automatic logic [7:0] reg_byte(input logic [REG_WIDTH-1:0] r, input int pos);
      logic [REG_WIDTH-1:0] shifted;
      shifted = '0;
      if (pos >= 0 && pos < REG_BYTES) begin
         shifted = r >> ((REG_BYTES - 1 - pos) * 8);
      end
      return shifted[7:0];
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // configuration registers
   always_comb begin
      pattern_in = pattern_ff;
      replace_in = replace_ff;
      length_in  = length_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PATTERN: pattern_in = csr_wdata;
            CSR_REPLACE: replace_in = csr_wdata;
            CSR_LENGTH:  length_in  = csr_wdata[LENGTH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // effective length, clamped to 1..MAX_PATTERN
   always_comb begin
      len_wide = 32'(length_ff);
      if (length_ff == '0) begin
         len_wide = 32'd1;
      end else if (len_wide > 32'(MAX_PATTERN)) begin
         len_wide = 32'(MAX_PATTERN);
      end
      eff_len = LW'(len_wide);
   end

   // insert, compare the newest bytes, replace on a hit
   always_comb begin
      fill_plus   = fill_ff + LW'(1);
      can_compare = (prot_ff == '0) && (fill_plus >= eff_len);
      base        = fill_plus - eff_len;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         ins[i]      = (LW'(i) == fill_ff) ? req_payload.data_in : win_ff[i];
         in_range[i] = (LW'(i) >= base) && (LW'(i) < fill_plus);
         byte_eq[i]  = ins[i] == reg_byte(pattern_ff, i - int'(base));
      end
      hit = can_compare && (&(~in_range | byte_eq));
      for (int i = 0; i < MAX_PATTERN; i++) begin
         patched[i] = (hit && in_range[i]) ? reg_byte(replace_ff, i - int'(base)) : ins[i];
      end
   end

   // how many bytes leave, and the window that stays
   always_comb begin
      if (req_payload.last_in) begin
         emit_count = fill_plus;
      end else if (fill_plus >= eff_len) begin
         emit_count = fill_plus - eff_len + LW'(1);
      end else begin
         emit_count = '0;
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         remain[i] = '0;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k == i + int'(emit_count)) begin
               remain[i] = patched[k];
            end
         end
      end
      count_next = (hit && (count_ff != '1)) ? count_ff + COUNT_WIDTH'(1) : count_ff;
      total_wide = 32'(count_next);
   end

   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      prot_in  = prot_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_payload.last_in) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
               win_in[i] = '0;
            end
            fill_in  = '0;
            prot_in  = '0;
            count_in = '0;
         end else begin
            win_in   = remain;
            fill_in  = fill_plus - emit_count;
            count_in = count_next;
            if (prot_ff != '0) begin
               prot_in = prot_ff - LW'(1);
            end else if (hit) begin
               prot_in = eff_len - LW'(1);
            end
         end
      end
   end

   always_comb begin
      push_valid = accept && (req_payload.last_in || (emit_count != '0));
      for (int i = 0; i < MAX_PATTERN; i++) begin
         push_bytes[i*8 +: 8] = patched[i];
      end
      push_ctl.count = BATCH_COUNT_WIDTH'(emit_count);
      push_ctl.last  = req_payload.last_in;
      push_ctl.total = total_wide[TOTAL_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PATTERN_RESET;
         replace_ff <= REPLACE_RESET;
         length_ff  <= LENGTH_RESET;
         for (int i = 0; i < MAX_PATTERN; i++) begin
            win_ff[i] <= '0;
         end
         fill_ff    <= '0;
         prot_ff    <= '0;
         count_ff   <= '0;
      end else begin
         pattern_ff <= pattern_in;
         replace_ff <= replace_in;
         length_ff  <= length_in;
         win_ff     <= win_in;
         fill_ff    <= fill_in;
         prot_ff    <= prot_in;
         count_ff   <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bpp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpp_queue import bpp_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = count_ff == CW'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/bpp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpp_back import bpp_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire logic [MAX_PATTERN*8-1:0] q_bytes,
   input  wire batch_ctl_type            q_ctl,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_payload
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [MAX_PATTERN*8-1:0] bytes_ff, bytes_in;
   batch_ctl_type            ctl_ff, ctl_in;
   logic                     valid_ff, valid_in;
   logic [IW-1:0]            idx_ff, idx_in;
   logic                     at_end;
   logic                     taken;
   logic                     done;

   assign at_end    = (BATCH_COUNT_WIDTH'(idx_ff) + BATCH_COUNT_WIDTH'(1)) == ctl_ff.count;
   assign taken     = valid_ff && !rsp_stall;
   assign done      = taken && at_end;
   assign q_pop     = q_valid && (!valid_ff || done);
   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_payload.data_out    = bytes_ff[{idx_ff, 3'b000} +: 8];
      rsp_payload.last_out    = ctl_ff.last && at_end;
      rsp_payload.match_total = ctl_ff.total;
   end

   always_comb begin
      bytes_in = bytes_ff;
      ctl_in   = ctl_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (q_pop) begin
         bytes_in = q_bytes;
         ctl_in   = q_ctl;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (taken) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      ctl_ff   <= ctl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   a_batch_not_empty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (ctl_ff.count != '0 &&
                    ctl_ff.count <= BATCH_COUNT_WIDTH'(MAX_PATTERN)))
      else $error("batch byte count out of range");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (taken && !at_end) |=> (idx_ff == $past(idx_ff) + IW'(1)))
      else $error("byte index did not advance");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (valid_ff && idx_ff == '0))
      else $error("new batch not started at first byte");

endmodule

`default_nettype wire

// ----- rtl/byte_pattern_patcher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// byte_pattern_patcher: stream find-and-replace over a byte stream framed by a
// last marker. The front keeps a sliding window as long as the programmed
// pattern (1 to MAX_PATTERN bytes, first byte in the top bits of the csr);
// when the newest bytes match, the whole window is overwritten with the
// replacement bytes and the match count goes up (saturating). Windows that
// overlap replaced bytes are not compared, so matches never overlap. Each
// input transaction turns into a batch of zero or more output bytes that
// waits in a small queue; the back side plays one byte per output
// transaction. Rate: one byte per cycle in both directions while the output
// is not stalled and the queue is not full; a byte leaves once it is the
// oldest byte of a full window, that is after pattern length minus one later
// bytes have come in. A batch written into the queue entry register is
// loaded into the back's batch register before its first byte is offered
// at the output. The transaction carrying last flushes the whole window as
// one batch of all bytes held (up to the pattern length, up to MAX_PATTERN
// right after the length shrinks), and the output port moves one byte a
// cycle; the queue keeps the input flowing meanwhile. match_total on the
// final byte is the count for the buffer, and the count restarts from zero
// for the next buffer. Registers must be written by the user only while the
// block is idle; the block does not enforce it. No clearing pass after reset.

module byte_pattern_patcher import bpp_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // configuration writes
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [REG_WIDTH-1:0]       csr_wdata,
   // input bytes
   input  wire logic                       req_valid,
   input  wire req_type                    req_payload,
   output logic                            req_stall,
   // patched bytes
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_payload
);

   localparam int CTL_W   = $bits(batch_ctl_type);
   localparam int BYTES_W = MAX_PATTERN * 8;
   localparam int ENTRY_W = BYTES_W + CTL_W;

   // front to queue
   logic                 push_valid;
   logic [BYTES_W-1:0]   push_bytes;
   batch_ctl_type        push_ctl;
   logic                 queue_full;

   // queue to back
   logic                 pop;
   logic                 pop_valid;
   logic [ENTRY_W-1:0]   pop_data;
   logic [BYTES_W-1:0]   pop_bytes;
   batch_ctl_type        pop_ctl;

   // front: holds the window, matches, replaces, and decides which bytes leave
   bpp_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .push_valid  (push_valid),
      .push_bytes  (push_bytes),
      .push_ctl    (push_ctl),
      .queue_full  (queue_full)
   );

   // batches waiting for the output side
   bpp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_bytes, push_ctl}),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   assign pop_bytes = pop_data[ENTRY_W-1:CTL_W];
   assign pop_ctl   = batch_ctl_type'(pop_data[CTL_W-1:0]);

   // back: serializes each batch into single-byte transactions
   bpp_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (pop_valid),
      .q_bytes     (pop_bytes),
      .q_ctl       (pop_ctl),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
